/* design/mafd_pkg.sv */
// ----------------------------------------------------------------------------
// mafd_pkg
// Shared types and constants of the ASCII frame decoder.
// ----------------------------------------------------------------------------
package mafd_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int BYTE_COUNT_W    = 9;
    localparam int Q_DEPTH         = 4;
    localparam int Q_AW            = $clog2(Q_DEPTH);
    localparam int Q_CW            = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] HEAD_CHAR_RST = 8'd58;
    localparam logic [7:0] TAIL_CHAR_RST = 8'd13;

    typedef logic [CNT_W-1:0] t_count;
    localparam t_count MAX_COUNT = t_count'(MAX_FRAME_BYTES);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_HEX   = 2'd2,
        ST_LRC_ERROR = 2'd3
    } t_status;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef enum logic {
        CFG_HEAD = 1'b0,
        CFG_TAIL = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic       close;
        logic       frame_bad;
        logic       hex_bad;
        logic [3:0] nibble;
    } t_cmd;

endpackage

/* design/mafd_front.sv */
// ----------------------------------------------------------------------------
// mafd_front
// Character intake: holds back one character, checks head and tail, turns
// each in-frame character into a nibble command and each frame end into a
// close command.
// ----------------------------------------------------------------------------
module mafd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_char_valid,
    input  logic [7:0]          i_char,
    input  logic                i_char_end,
    input  logic                i_q_full,
    output logic                o_char_ready,
    output logic                o_push,
    output mafd_pkg::t_cmd      o_cmd
);

    logic [7:0] r_head_char, r_tail_char;
    logic       r_expect_first, n_expect_first;
    logic       r_head_bad, n_head_bad;
    logic [7:0] r_held_char, n_held_char;
    logic       r_held_valid, n_held_valid;
    logic [1:0] r_char_cnt, n_char_cnt;

    logic       accept;
    logic       digit_ok;
    logic [3:0] digit_val;
    logic [7:0] sub_num, sub_up, sub_lo;

    assign o_char_ready = !i_q_full;
    assign accept       = i_char_valid && o_char_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_char <= mafd_pkg::HEAD_CHAR_RST;
            r_tail_char <= mafd_pkg::TAIL_CHAR_RST;
        end else if (i_cfg_valid) begin
            unique case (mafd_pkg::t_cfg_reg'(i_cfg_index))
                mafd_pkg::CFG_HEAD: r_head_char <= i_cfg_data;
                mafd_pkg::CFG_TAIL: r_tail_char <= i_cfg_data;
                default:            r_head_char <= r_head_char;
            endcase
        end
    end

    always_comb begin
        sub_num   = r_held_char - 8'h30;
        sub_up    = r_held_char - 8'h37;
        sub_lo    = r_held_char - 8'h57;
        digit_ok  = 1'b1;
        digit_val = 4'd0;
        if (r_held_char >= 8'h30 && r_held_char <= 8'h39) begin
            digit_val = sub_num[3:0];
        end else if (r_held_char >= 8'h41 && r_held_char <= 8'h46) begin
            digit_val = sub_up[3:0];
        end else if (r_held_char >= 8'h61 && r_held_char <= 8'h66) begin
            digit_val = sub_lo[3:0];
        end else begin
            digit_ok = 1'b0;
        end
    end

    always_comb begin
        n_expect_first = r_expect_first;
        n_head_bad     = r_head_bad;
        n_held_char    = r_held_char;
        n_held_valid   = r_held_valid;
        n_char_cnt     = r_char_cnt;
        o_push         = 1'b0;
        o_cmd          = '0;
        if (accept) begin
            if (r_expect_first) begin
                n_head_bad   = (i_char != r_head_char);
                n_char_cnt   = 2'd1;
                n_held_valid = 1'b0;
                n_held_char  = 8'd0;
                if (i_char_end) begin
                    o_push          = 1'b1;
                    o_cmd.close     = 1'b1;
                    o_cmd.frame_bad = 1'b1;
                end else begin
                    n_expect_first = 1'b0;
                end
            end else if (!i_char_end) begin
                if (r_held_valid) begin
                    o_push        = 1'b1;
                    o_cmd.hex_bad = !digit_ok;
                    o_cmd.nibble  = digit_val;
                end
                n_held_char  = i_char;
                n_held_valid = 1'b1;
                if (r_char_cnt != 2'd3) begin
                    n_char_cnt = r_char_cnt + 2'd1;
                end
            end else begin
                o_push          = 1'b1;
                o_cmd.close     = 1'b1;
                o_cmd.frame_bad = r_head_bad || (r_char_cnt < 2'd2) || !r_held_valid ||
                                  (r_held_char != r_tail_char);
                n_expect_first  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_first <= 1'b1;
            r_head_bad     <= 1'b0;
            r_held_valid   <= 1'b0;
            r_char_cnt     <= 2'd0;
        end else begin
            r_expect_first <= n_expect_first;
            r_head_bad     <= n_head_bad;
            r_held_valid   <= n_held_valid;
            r_char_cnt     <= n_char_cnt;
        end
        r_held_char <= n_held_char;
    end

endmodule

/* design/mafd_queue.sv */
// ----------------------------------------------------------------------------
// mafd_queue
// Short command queue between intake and decode.
// ----------------------------------------------------------------------------
module mafd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mafd_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output mafd_pkg::t_cmd      o_cmd
);

    localparam logic [mafd_pkg::Q_AW-1:0] LAST_PTR = mafd_pkg::Q_AW'(mafd_pkg::Q_DEPTH - 1);

    mafd_pkg::t_cmd               r_mem [mafd_pkg::Q_DEPTH];
    logic [mafd_pkg::Q_AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [mafd_pkg::Q_CW-1:0]    r_count;

    assign o_full  = (r_count == mafd_pkg::Q_CW'(mafd_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");

endmodule

/* design/mafd_back.sv */
// ----------------------------------------------------------------------------
// mafd_back
// Decode: pairs nibbles into bytes, keeps the LRC sum and byte count, emits
// data one byte late and the frame status on close, through an output
// register.
// ----------------------------------------------------------------------------
module mafd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  mafd_pkg::t_cmd                      i_cmd,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_kind,
    output logic [7:0]                          o_data,
    output logic [1:0]                          o_status,
    output logic [mafd_pkg::BYTE_COUNT_W-1:0]   o_count,
    output logic                                o_last
);

    logic                   r_phase, n_phase;
    logic [3:0]             r_high, n_high;
    logic [7:0]             r_pend, n_pend;
    logic                   r_pend_valid, n_pend_valid;
    logic [7:0]             r_lrc, n_lrc;
    mafd_pkg::t_count       r_data_count, n_data_count;
    logic                   r_hex_bad, n_hex_bad;
    logic                   r_overflow, n_overflow;

    logic                   r_out_valid;
    logic                   r_out_kind, n_out_kind;
    logic [7:0]             r_out_data, n_out_data;
    logic [1:0]             r_out_status, n_out_status;
    logic [mafd_pkg::BYTE_COUNT_W-1:0] r_out_count, n_out_count;
    logic                   r_out_last, n_out_last;
    logic                   emit;

    logic [7:0]             new_byte;
    logic [mafd_pkg::CNT_W+mafd_pkg::BYTE_COUNT_W-1:0] count_wide;

    assign o_pop      = !i_q_empty && (!r_out_valid || i_ready);
    assign new_byte   = {r_high, i_cmd.nibble};
    assign count_wide = {{mafd_pkg::BYTE_COUNT_W{1'b0}}, r_data_count};

    always_comb begin
        n_phase      = r_phase;
        n_high       = r_high;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_lrc        = r_lrc;
        n_data_count = r_data_count;
        n_hex_bad    = r_hex_bad;
        n_overflow   = r_overflow;
        emit         = 1'b0;
        n_out_kind   = mafd_pkg::KIND_DATA;
        n_out_data   = 8'd0;
        n_out_status = mafd_pkg::ST_OK;
        n_out_count  = '0;
        n_out_last   = 1'b0;
        if (o_pop) begin
            if (i_cmd.close) begin
                emit        = 1'b1;
                n_out_kind  = mafd_pkg::KIND_STATUS;
                n_out_last  = 1'b1;
                n_out_count = count_wide[mafd_pkg::BYTE_COUNT_W-1:0];
                if (i_cmd.frame_bad || r_phase || !r_pend_valid || r_overflow) begin
                    n_out_status = mafd_pkg::ST_INVALID;
                end else if (r_hex_bad) begin
                    n_out_status = mafd_pkg::ST_NOT_HEX;
                end else if (r_lrc != 8'd0) begin
                    n_out_status = mafd_pkg::ST_LRC_ERROR;
                end
                n_phase      = 1'b0;
                n_high       = 4'd0;
                n_pend       = 8'd0;
                n_pend_valid = 1'b0;
                n_lrc        = 8'd0;
                n_data_count = '0;
                n_hex_bad    = 1'b0;
                n_overflow   = 1'b0;
            end else begin
                if (i_cmd.hex_bad) begin
                    n_hex_bad = 1'b1;
                end
                if (!r_phase) begin
                    n_high  = i_cmd.nibble;
                    n_phase = 1'b1;
                end else begin
                    n_phase = 1'b0;
                    n_lrc   = r_lrc + new_byte;
                    if (r_pend_valid) begin
                        if (r_data_count >= mafd_pkg::MAX_COUNT) begin
                            n_overflow = 1'b1;
                        end else begin
                            n_data_count = r_data_count + 1'b1;
                            emit         = 1'b1;
                            n_out_data   = r_pend;
                        end
                    end
                    n_pend       = new_byte;
                    n_pend_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= 1'b0;
            r_high       <= 4'd0;
            r_pend       <= 8'd0;
            r_pend_valid <= 1'b0;
            r_lrc        <= 8'd0;
            r_data_count <= '0;
            r_hex_bad    <= 1'b0;
            r_overflow   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_high       <= n_high;
            r_pend       <= n_pend;
            r_pend_valid <= n_pend_valid;
            r_lrc        <= n_lrc;
            r_data_count <= n_data_count;
            r_hex_bad    <= n_hex_bad;
            r_overflow   <= n_overflow;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (emit) begin
            r_out_kind   <= n_out_kind;
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
            r_out_count  <= n_out_count;
            r_out_last   <= n_out_last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_kind   = r_out_kind;
    assign o_data   = r_out_data;
    assign o_status = r_out_status;
    assign o_count  = r_out_count;
    assign o_last   = r_out_last;

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == mafd_pkg::KIND_DATA) |->
            (o_status == mafd_pkg::ST_OK && o_count == '0 && !o_last))
        else $error("data beat carries status fields");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == mafd_pkg::KIND_STATUS) |-> (o_last && o_data == 8'd0))
        else $error("status beat malformed");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_data_count <= mafd_pkg::MAX_COUNT)
        else $error("byte count beyond frame limit");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.close) |=> (r_data_count == '0 && !r_pend_valid && !r_phase))
        else $error("frame state not cleared on close");

endmodule

/* design/modbus_ascii_frame_decoder_unit.sv */
// ----------------------------------------------------------------------------
// modbus_ascii_frame_decoder_unit
// ASCII frame decoder with LRC check: hex digit pairs to bytes, one status
// beat per frame.
//
//   channel   dir   handshake                 payload
//   s_axis    in    tvalid/tready             tdata rx_char, tlast frame_end
//   m_axis    out   tvalid/tready             tdata/tuser/tlast result
//   cfg       in    valid/ready (always 1)    index, data
//
// One character beat per cycle while the queue has room; a result passes the
// queue register and then the output register on its way out.
// A four-entry command queue separates intake from decode; intake stalls
// only when it is full, decode stalls only when the output register holds.
// Reset restores head ':' and tail CR and starts waiting for a frame head.
// ----------------------------------------------------------------------------
module modbus_ascii_frame_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // [7:0] rx_char
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,    // [7:0] data_byte, [9:8] frame_status,
                                           // [18:10] byte_count, [23:19] zero
    output logic        o_m_axis_tuser,    // [0] result_kind
    output logic        o_m_axis_tlast
);

    mafd_pkg::t_cmd  push_cmd, pop_cmd;
    logic            push, pop, q_full, q_empty;
    logic [7:0]      out_data;
    logic [1:0]      out_status;
    logic [mafd_pkg::BYTE_COUNT_W-1:0] out_count;

    assign o_cfg_ready = 1'b1;

    mafd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_char_valid (i_s_axis_tvalid),
        .i_char       (i_s_axis_tdata),
        .i_char_end   (i_s_axis_tlast),
        .i_q_full     (q_full),
        .o_char_ready (o_s_axis_tready),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    mafd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (pop_cmd)
    );

    mafd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (pop_cmd),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_kind    (o_m_axis_tuser),
        .o_data    (out_data),
        .o_status  (out_status),
        .o_count   (out_count),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {5'd0, out_count, out_status, out_data};

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ASCII frame decoder with LRC check. A short
// table of hand-picked frames runs first, then random frames under several
// head/tail settings, mostly well formed, the rest with a bad LRC, non-hex
// digits, an odd digit count, a wrong head or tail, short frames and noise,
// plus one frame at the byte count limit and one past it. Every result beat
// is compared field by field with the bench's own decoder model.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BEATS  = 80;
    localparam int NUM_PHASES   = 5;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef struct packed {
        mafd_pkg::t_kind   kind;
        logic [7:0]        data;
        mafd_pkg::t_status status;
        logic [8:0]        count;
        logic              last;
    } t_frame_result;

    typedef struct {
        logic [7:0]        ch;
        logic              last;
        bit                typed;
        mafd_pkg::t_status st;
        int                cnt;
    } t_dir_row;

    typedef enum {
        FL_NONE, FL_LRC, FL_HEX, FL_ODD, FL_HEAD, FL_TAIL, FL_SHORT, FL_NOISE
    } t_flaw;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = mafd_pkg::CFG_HEAD;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'd0;
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b1;
    logic [23:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;

    modbus_ascii_frame_decoder_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    t_frame_result frame_results_q[$];
    t_dir_row      dir_rows[$];
    int            errors = 0;
    int            cycle_count = 0;
    int            beats_sent = 0;
    int            burst_left = 0;
    int            tx_mode = 0;
    int            rx_mode = 0;
    int            stall_left = 0;

    // decoder model state
    logic [7:0] cfg_head = mafd_pkg::HEAD_CHAR_RST;
    logic [7:0] cfg_tail = mafd_pkg::TAIL_CHAR_RST;
    bit         at_head = 1'b1;
    bit         head_wrong;
    logic [7:0] held_ch;
    bit         held_vld;
    int         chars_seen;
    logic [3:0] hi_nib;
    bit         odd_nib;
    logic [7:0] prev_byte;
    bit         prev_vld;
    logic [7:0] lrc_acc;
    int         bytes_out;
    bit         hex_err;
    bit         over_limit;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void clear_frame();
        head_wrong = 1'b0;
        held_ch    = 8'd0;
        held_vld   = 1'b0;
        chars_seen = 0;
        hi_nib     = 4'd0;
        odd_nib    = 1'b0;
        prev_byte  = 8'd0;
        prev_vld   = 1'b0;
        lrc_acc    = 8'd0;
        bytes_out  = 0;
        hex_err    = 1'b0;
        over_limit = 1'b0;
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c, output bit ok);
        ok = 1'b1;
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
        if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
        ok = 1'b0;
        return 4'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 10) return 8'("0" + nib);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + nib - 10);
    endfunction

    // Advance the model by one character; 1 when it yields a result beat.
    function automatic bit decode_char(input logic [7:0] c, input logic last,
                                       output t_frame_result r);
        logic [3:0] v;
        logic [7:0] b;
        bit         ok;
        bit         got;

        r   = '0;
        got = 1'b0;
        if (at_head) begin
            clear_frame();
            head_wrong = (c != cfg_head);
            chars_seen = 1;
            if (last) begin
                r.kind   = mafd_pkg::KIND_STATUS;
                r.status = mafd_pkg::ST_INVALID;
                r.last   = 1'b1;
                clear_frame();
                return 1'b1;
            end
            at_head = 1'b0;
            return 1'b0;
        end
        if (!last) begin
            if (held_vld) begin
                v = hex_nibble(held_ch, ok);
                if (!ok) hex_err = 1'b1;
                if (!odd_nib) begin
                    hi_nib  = v;
                    odd_nib = 1'b1;
                end else begin
                    odd_nib = 1'b0;
                    b       = {hi_nib, v};
                    lrc_acc = lrc_acc + b;
                    if (prev_vld) begin
                        if (bytes_out >= mafd_pkg::MAX_FRAME_BYTES) begin
                            over_limit = 1'b1;
                        end else begin
                            bytes_out++;
                            r.kind = mafd_pkg::KIND_DATA;
                            r.data = prev_byte;
                            got    = 1'b1;
                        end
                    end
                    prev_byte = b;
                    prev_vld  = 1'b1;
                end
            end
            held_ch  = c;
            held_vld = 1'b1;
            if (chars_seen < 3) chars_seen++;
            return got;
        end
        // the held character is the tail, this one is dropped
        r.kind  = mafd_pkg::KIND_STATUS;
        r.last  = 1'b1;
        r.count = 9'(bytes_out);
        if (head_wrong || chars_seen < 2 || !held_vld || held_ch != cfg_tail ||
            odd_nib || !prev_vld || over_limit) begin
            r.status = mafd_pkg::ST_INVALID;
        end else if (hex_err) begin
            r.status = mafd_pkg::ST_NOT_HEX;
        end else if (lrc_acc != 8'd0) begin
            r.status = mafd_pkg::ST_LRC_ERROR;
        end else begin
            r.status = mafd_pkg::ST_OK;
        end
        clear_frame();
        at_head = 1'b1;
        return 1'b1;
    endfunction

    function automatic void add_row(input logic [7:0] ch, input logic last,
                                    input bit typed, input mafd_pkg::t_status st,
                                    input int cnt);
        dir_rows.push_back('{ch, last, typed, st, cnt});
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    task automatic write_reg(input mafd_pkg::t_cfg_reg idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == mafd_pkg::CFG_HEAD) cfg_head = val;
        else cfg_tail = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_beat(input logic [7:0] c, input logic last,
                             output bit got, output t_frame_result r);
        int gap;

        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (tx_mode == 0) ? 0 : $urandom_range(0, (tx_mode == 1) ? 2 : 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        got = decode_char(c, last, r);
        beats_sent++;
    endtask

    task automatic hold_for_drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_frame(input t_flaw flaw, input int nbytes);
        logic [7:0]    fr[$];
        logic [7:0]    b;
        logic [7:0]    sum;
        logic [7:0]    c;
        bit            ok;
        bit            got;
        int            pos;
        t_frame_result r;

        sum = 8'd0;
        if (flaw == FL_NOISE) begin
            repeat ($urandom_range(1, 6)) fr.push_back(8'($urandom_range(0, 255)));
        end else if (flaw == FL_SHORT) begin
            fr.push_back(cfg_head);
            case ($urandom_range(0, 2))
                0: ;
                1: fr.push_back(8'($urandom_range(0, 255)));
                default: begin
                    fr.push_back(cfg_tail);
                    fr.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end else begin
            fr.push_back(cfg_head);
            repeat (nbytes) begin
                b   = 8'($urandom_range(0, 255));
                sum = sum + b;
                fr.push_back(hex_char(b[7:4]));
                fr.push_back(hex_char(b[3:0]));
            end
            b = 8'd0 - sum;
            if (flaw == FL_LRC) b = b ^ 8'($urandom_range(1, 255));
            fr.push_back(hex_char(b[7:4]));
            fr.push_back(hex_char(b[3:0]));
            pos = $urandom_range(1, fr.size() - 1);
            if (flaw == FL_HEX) begin
                do begin
                    c = 8'($urandom_range(0, 255));
                    void'(hex_nibble(c, ok));
                end while (ok);
                fr[pos] = c;
            end
            if (flaw == FL_ODD) fr.delete(pos);
            if (flaw == FL_HEAD) fr[0] = cfg_head ^ 8'($urandom_range(1, 255));
            fr.push_back((flaw == FL_TAIL) ? cfg_tail ^ 8'($urandom_range(1, 255))
                                           : cfg_tail);
            fr.push_back(8'($urandom_range(0, 255)));
        end
        foreach (fr[i]) begin
            send_beat(fr[i], i == fr.size() - 1, got, r);
            if (got) frame_results_q.push_back(r);
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (rx_mode != 0 && $urandom_range(0, 99) < ((rx_mode == 1) ? 15 : 45))
                stall_left = $urandom_range(1, (rx_mode == 1) ? 3 : 8);
        end
    end

    always @(posedge i_clk) begin
        t_frame_result w;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (frame_results_q.size() == 0) begin
                report_mismatch("unexpected result beat", int'(o_m_axis_tdata), 0);
            end else begin
                w = frame_results_q.pop_front();
                if (o_m_axis_tuser !== w.kind)
                    report_mismatch("result_kind", int'(o_m_axis_tuser), int'(w.kind));
                if (o_m_axis_tdata[7:0] !== w.data)
                    report_mismatch("data_byte", int'(o_m_axis_tdata[7:0]), int'(w.data));
                if (o_m_axis_tdata[9:8] !== w.status)
                    report_mismatch("frame_status", int'(o_m_axis_tdata[9:8]),
                                    int'(w.status));
                if (o_m_axis_tdata[18:10] !== w.count)
                    report_mismatch("byte_count", int'(o_m_axis_tdata[18:10]),
                                    int'(w.count));
                if (o_m_axis_tlast !== w.last)
                    report_mismatch("frame_last", int'(o_m_axis_tlast), int'(w.last));
            end
        end
    end

    initial begin
        t_frame_result r;
        t_frame_result typed_r;
        bit            got;
        int            sel;
        int            frames;
        int            saved_beats;
        t_flaw         flaw;

        clear_frame();

        // one-character frame
        add_row(":", 1'b1, 1'b1, mafd_pkg::ST_INVALID, 0);
        // odd digit count
        add_row(":", 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row("1", 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row(CH_CR, 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row(CH_LF, 1'b1, 1'b1, mafd_pkg::ST_INVALID, 0);
        // no digits, so no LRC byte
        add_row(":", 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row(CH_CR, 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row(CH_LF, 1'b1, 1'b1, mafd_pkg::ST_INVALID, 0);
        // LRC error
        add_row(":", 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row("1", 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row("2", 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row(CH_CR, 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row(CH_LF, 1'b1, 1'b1, mafd_pkg::ST_LRC_ERROR, 0);
        // non-hex digit
        add_row(":", 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row("0", 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row("G", 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row(CH_CR, 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row(CH_LF, 1'b1, 1'b1, mafd_pkg::ST_NOT_HEX, 0);
        // data byte 0xFF in mixed case, good LRC
        add_row(":", 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row("F", 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row("f", 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row("0", 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row("1", 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row(CH_CR, 1'b0, 1'b0, mafd_pkg::ST_OK, 0);
        add_row(CH_LF, 1'b1, 1'b0, mafd_pkg::ST_OK, 0);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].ch, dir_rows[i].last, got, r);
            if (dir_rows[i].typed) begin
                typed_r        = '0;
                typed_r.kind   = mafd_pkg::KIND_STATUS;
                typed_r.status = dir_rows[i].st;
                typed_r.count  = 9'(dir_rows[i].cnt);
                typed_r.last   = 1'b1;
                frame_results_q.push_back(typed_r);
            end else if (got) begin
                frame_results_q.push_back(r);
            end
        end

        beats_sent = 0;
        frames     = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            hold_for_drain();
            repeat (8) @(posedge i_clk);
            case (p)
                0: begin
                    write_reg(mafd_pkg::CFG_HEAD, mafd_pkg::HEAD_CHAR_RST);
                    write_reg(mafd_pkg::CFG_TAIL, mafd_pkg::TAIL_CHAR_RST);
                    tx_mode = 0;
                    rx_mode = 0;
                end
                1: begin
                    write_reg(mafd_pkg::CFG_TAIL, 8'h00);
                    write_reg(mafd_pkg::CFG_HEAD, 8'hFF);
                    tx_mode = 1;
                    rx_mode = 2;
                end
                2: begin
                    write_reg(mafd_pkg::CFG_HEAD, 8'h00);
                    write_reg(mafd_pkg::CFG_TAIL, 8'hFF);
                    tx_mode = 2;
                    rx_mode = 1;
                end
                3: begin
                    write_reg(mafd_pkg::CFG_HEAD, 8'($urandom_range(0, 255)));
                    write_reg(mafd_pkg::CFG_TAIL, 8'($urandom_range(0, 255)));
                    tx_mode = $urandom_range(0, 2);
                    rx_mode = $urandom_range(0, 2);
                end
                default: begin
                    write_reg(mafd_pkg::CFG_TAIL, mafd_pkg::TAIL_CHAR_RST);
                    write_reg(mafd_pkg::CFG_HEAD, mafd_pkg::HEAD_CHAR_RST);
                    tx_mode = 2;
                    rx_mode = 2;
                end
            endcase
            if (p == 1) begin
                // byte count right at the limit, then one past it
                saved_beats = beats_sent;
                send_frame(FL_NONE, mafd_pkg::MAX_FRAME_BYTES);
                send_frame(FL_NONE, mafd_pkg::MAX_FRAME_BYTES + 1);
                beats_sent = saved_beats;
            end
            while (beats_sent < (p + 1) * PHASE_BEATS) begin
                sel = $urandom_range(0, 99);
                if (sel < 70)      flaw = FL_NONE;
                else if (sel < 78) flaw = FL_LRC;
                else if (sel < 83) flaw = FL_HEX;
                else if (sel < 87) flaw = FL_ODD;
                else if (sel < 91) flaw = FL_HEAD;
                else if (sel < 95) flaw = FL_TAIL;
                else if (sel < 98) flaw = FL_SHORT;
                else               flaw = FL_NOISE;
                send_frame(flaw, ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6)
                                                            : $urandom_range(7, 40));
                frames++;
                if (frames % 40 == 20) hold_for_drain();
            end
        end

        hold_for_drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/mafd_pkg.sv
design/mafd_front.sv
design/mafd_queue.sv
design/mafd_back.sv
design/modbus_ascii_frame_decoder_unit.sv
verif/tb.sv
